FILE: hw/rtl/stb_pkg.sv
package stb_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 8192;

  localparam int COUNT_W = 14;
  localparam int INDEX_W = 13;
  localparam int KEY_W   = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 14'd4888;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic               was_lookup;
    logic               found;
    logic [INDEX_W-1:0] match_index;
  } result_t;

endpackage

FILE: hw/rtl/stb_key_mem.sv
module stb_key_mem #(
  parameter int TABLE_DEPTH = stb_pkg::DEFAULT_TABLE_DEPTH,
  localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [stb_pkg::KEY_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [stb_pkg::KEY_W-1:0] rd_data
);

  logic [stb_pkg::KEY_W-1:0] keys [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= keys[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/stb_search_ctrl.sv
module stb_search_ctrl #(
  parameter int TABLE_DEPTH = stb_pkg::DEFAULT_TABLE_DEPTH,
  localparam int ADDR_W = $clog2(TABLE_DEPTH),
  localparam int BOUND_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [stb_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [stb_pkg::INDEX_W-1:0] entry_index,
  input  logic [stb_pkg::KEY_W-1:0]   key_value,
  output logic                        mem_wr_en,
  output logic [ADDR_W-1:0]           mem_wr_addr,
  output logic [stb_pkg::KEY_W-1:0]   mem_wr_data,
  output logic                        mem_rd_en,
  output logic [ADDR_W-1:0]           mem_rd_addr,
  input  logic [stb_pkg::KEY_W-1:0]   mem_rd_data,
  output logic                        res_valid,
  input  logic                        res_take,
  output stb_pkg::result_t            res
);

  stb_pkg::state_t state, state_next;

  logic [stb_pkg::COUNT_W-1:0] entry_count;
  logic [stb_pkg::KEY_W-1:0]   key, key_next;
  logic [BOUND_W-1:0]          low, low_next;
  logic [BOUND_W-1:0]          high, high_next;
  logic [ADDR_W-1:0]           mid, mid_next;
  stb_pkg::result_t            res_next;

  logic [BOUND_W-1:0] count_sat;
  logic [BOUND_W-1:0] step_low;
  logic [BOUND_W-1:0] step_high;
  logic               key_less;
  logic               key_equal;

  // The interval is [low, high): high is one past the last candidate entry.
  function automatic logic [ADDR_W-1:0] mid_of(input logic [BOUND_W-1:0] lo,
                                               input logic [BOUND_W-1:0] hi);
    logic [BOUND_W:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} - {{BOUND_W{1'b0}}, 1'b1};
    return ADDR_W'(sum >> 1);
  endfunction

  assign count_sat = (int'(entry_count) > TABLE_DEPTH) ? BOUND_W'(TABLE_DEPTH)
                                                      : BOUND_W'(entry_count);
  assign key_less  = $signed(key) < $signed(mem_rd_data);
  assign key_equal = key == mem_rd_data;
  assign step_low  = key_less ? low : BOUND_W'(mid) + BOUND_W'(1);
  assign step_high = key_less ? BOUND_W'(mid) : high;

  assign in_stall    = state != stb_pkg::ST_IDLE;
  assign res_valid   = state == stb_pkg::ST_RESULT;
  assign mem_wr_addr = ADDR_W'(entry_index);
  assign mem_wr_data = key_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= stb_pkg::ST_IDLE;
      entry_count <= stb_pkg::COUNT_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        entry_count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    key  <= key_next;
    low  <= low_next;
    high <= high_next;
    mid  <= mid_next;
    res  <= res_next;
  end

  always_comb begin
    state_next  = state;
    key_next    = key;
    low_next    = low;
    high_next   = high;
    mid_next    = mid;
    res_next    = res;
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = mid_of(low, high);
    case (state)
      stb_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_next = '0;
          if (mode == stb_pkg::MODE_WRITE) begin
            mem_wr_en  = int'(entry_index) < TABLE_DEPTH;
            state_next = stb_pkg::ST_RESULT;
          end else begin
            res_next.was_lookup = 1'b1;
            key_next   = key_value;
            low_next   = '0;
            high_next  = count_sat;
            state_next = stb_pkg::ST_PROBE;
          end
        end
      end
      stb_pkg::ST_PROBE: begin
        if (low < high) begin
          mem_rd_en  = 1'b1;
          mid_next   = mid_of(low, high);
          state_next = stb_pkg::ST_COMPARE;
        end else begin
          state_next = stb_pkg::ST_RESULT;
        end
      end
      stb_pkg::ST_COMPARE: begin
        if (key_equal) begin
          res_next.found       = 1'b1;
          res_next.match_index = stb_pkg::INDEX_W'(mid);
          state_next           = stb_pkg::ST_RESULT;
        end else begin
          low_next  = step_low;
          high_next = step_high;
          if (step_low < step_high) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = mid_of(step_low, step_high);
            mid_next    = mid_of(step_low, step_high);
          end else begin
            state_next = stb_pkg::ST_RESULT;
          end
        end
      end
      stb_pkg::ST_RESULT: begin
        if (res_take) begin
          state_next = stb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/stb_out_stage.sv
module stb_out_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_valid,
  output logic                        res_take,
  input  stb_pkg::result_t            res,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        was_lookup,
  output logic                        found,
  output logic [stb_pkg::INDEX_W-1:0] match_index
);

  stb_pkg::result_t held;

  assign res_take    = res_valid && (!out_valid || !out_stall);
  assign was_lookup  = held.was_lookup;
  assign found       = held.found;
  assign match_index = held.match_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      held <= res;
    end
  end

endmodule

FILE: hw/rtl/sorted_table_binary_search_unit.sv
// Binary search over a sorted table of signed 32-bit keys held in one synchronous
// RAM. A write word stores key_value at entry_index and is acknowledged with
// was_lookup=0; writes at or beyond TABLE_DEPTH are dropped but still acknowledged.
// A lookup word searches entries 0 to entry_count-1 (entry_count saturates at
// TABLE_DEPTH) and returns found and match_index, or found=0 with match_index=0.
// One word is in work at a time. A write goes from acceptance straight to its
// result state; a lookup passes a probe state and then one compare per halving
// step, at most floor(log2(entry_count))+1 steps. When the result enters the
// output register the unit returns to idle, and the next word is accepted from
// there. Each step is one RAM read followed by a compare that also issues
// the next read address. The output register lets the result wait for the
// consumer while the next word is accepted. Every entry a lookup reaches must
// have been written since reset.
module sorted_table_binary_search_unit #(
  parameter int TABLE_DEPTH = stb_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [stb_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [stb_pkg::INDEX_W-1:0] entry_index,
  input  logic [stb_pkg::KEY_W-1:0]   key_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        was_lookup,
  output logic                        found,
  output logic [stb_pkg::INDEX_W-1:0] match_index
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic                      mem_wr_en;
  logic [ADDR_W-1:0]         mem_wr_addr;
  logic [stb_pkg::KEY_W-1:0] mem_wr_data;
  logic                      mem_rd_en;
  logic [ADDR_W-1:0]         mem_rd_addr;
  logic [stb_pkg::KEY_W-1:0] mem_rd_data;
  logic                      res_valid;
  logic                      res_take;
  stb_pkg::result_t          res;

  stb_key_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_key_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  stb_search_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_search_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .entry_index(entry_index),
    .key_value  (key_value),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  stb_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .was_lookup (was_lookup),
    .found      (found),
    .match_index(match_index)
  );

endmodule
